// ===== rtl/bct_pkg.sv =====
// ----------------------------------------------------------------------------
// Bus chain parent tracker package
// Shared widths, status codes and the stack command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bct_pkg;

   localparam int ADDR_W        = 16;
   localparam int PORTS_W       = 3;
   localparam int STATUS_W      = 2;
   localparam int DEF_STACK_DEPTH = 16;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_PORT  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic       valid;
      logic       clear;
      logic       pop;
      logic [1:0] push_n;
      addr_type   data;
   } stack_cmd_type;

   typedef struct packed {
      addr_type top;
      logic     empty;
      logic     overflow;
   } stack_status_type;

endpackage

`default_nettype wire

// ===== rtl/bct_if.sv =====
// ----------------------------------------------------------------------------
// Bus chain parent tracker channels
// Valid/ready channels for node beats and parent result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface bct_req_if
   import bct_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               start_req;
   addr_type           node_address;
   logic [PORTS_W-1:0] open_ports;

   modport source (output valid, output start_req, output node_address,
                   output open_ports, input ready);
   modport sink   (input valid, input start_req, input node_address,
                   input open_ports, output ready);
endinterface

interface bct_rsp_if
   import bct_pkg::*;
();
   logic                valid;
   logic                ready;
   addr_type            node_out;
   addr_type            parent_address;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output node_out, output parent_address,
                   output status, input ready);
   modport sink   (input valid, input node_out, input parent_address,
                   input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/bct_stack.sv =====
// ----------------------------------------------------------------------------
// Branch point stack
// Two memory banks for even and odd entries, so that two pushes fit in one
// cycle. The entry below the next count is read ahead every cycle, with a
// bypass for an entry written in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bct_stack
   import bct_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire stack_cmd_type    cmd,
   output      stack_status_type stat
);

   localparam int CW         = $clog2(STACK_DEPTH + 1);
   localparam int BANK_DEPTH = (STACK_DEPTH + 1) / 2;
   localparam int RW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam logic [CW:0] DEPTH_W = (CW + 1)'(STACK_DEPTH);

   addr_type mem_even [BANK_DEPTH];
   addr_type mem_odd  [BANK_DEPTH];

   logic [CW-1:0] count_ff, count_in;
   addr_type      q_even_ff, q_odd_ff;
   logic          par_ff, par_in;
   logic          hit_ff, hit_in;
   addr_type      byp_ff;

   logic [CW-1:0] c_eff;
   logic [CW-1:0] w1_idx;
   logic [CW-1:0] rd_idx;
   logic [CW-1:0] rd_full;
   logic [RW-1:0] rd_row;
   logic          fit0, fit1, we0, we1;

   assign c_eff  = cmd.clear ? '0 : count_ff;
   assign w1_idx = c_eff + 1'b1;
   assign fit0   = ({1'b0, c_eff} < DEPTH_W);
   assign fit1   = ({1'b0, c_eff} + 1'b1 < DEPTH_W);
   assign we0    = cmd.valid && !cmd.pop && (cmd.push_n != 2'd0) && fit0;
   assign we1    = cmd.valid && !cmd.pop && (cmd.push_n == 2'd2) && fit1;

   always_comb begin
      if (!cmd.valid) begin
         count_in = count_ff;
      end else if (cmd.pop) begin
         count_in = (c_eff != '0) ? c_eff - 1'b1 : '0;
      end else begin
         count_in = c_eff + CW'(we0) + CW'(we1);
      end
   end

   assign rd_idx  = count_in - 1'b1;
   assign rd_full = rd_idx >> 1;
   assign rd_row  = (rd_full < CW'(BANK_DEPTH)) ? RW'(rd_full) : '0;
   assign par_in  = rd_idx[0];
   assign hit_in  = cmd.valid && !cmd.pop && (count_in != c_eff);

   always_ff @(posedge clock) begin
      if (we0 && !c_eff[0]) begin
         mem_even[RW'(c_eff >> 1)] <= cmd.data;
      end else if (we1 && !w1_idx[0]) begin
         mem_even[RW'(w1_idx >> 1)] <= cmd.data;
      end
      if (we0 && c_eff[0]) begin
         mem_odd[RW'(c_eff >> 1)] <= cmd.data;
      end else if (we1 && w1_idx[0]) begin
         mem_odd[RW'(w1_idx >> 1)] <= cmd.data;
      end
      q_even_ff <= mem_even[rd_row];
      q_odd_ff  <= mem_odd[rd_row];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         hit_ff   <= hit_in;
      end
      par_ff <= par_in;
      byp_ff <= cmd.data;
   end

   always_comb begin
      stat.top      = hit_ff ? byp_ff : (par_ff ? q_odd_ff : q_even_ff);
      stat.empty    = (c_eff == '0);
      stat.overflow = !cmd.pop && (((cmd.push_n != 2'd0) && !fit0) ||
                                   ((cmd.push_n == 2'd2) && !fit1));
   end

endmodule

`default_nettype wire

// ===== rtl/bus_chain_parent_tracker.sv =====
// The result beat of an accepted node beat is registered and shown in the next cycle.
// Throughput: one node per cycle unless the receiver stalls; the stack pop reads the
// top entry that the two-bank stack memory fetched ahead in the previous cycle.
// A result waiting in the output register holds off the next node only while
// the receiver stalls. Reset is synchronous, active high: it empties the
// stack, clears the last node and drops any pending result; no stack entry is cleared.
// ----------------------------------------------------------------------------
// Bus chain parent tracker
// Reports the parent address of each node of a bus scan.
// ----------------------------------------------------------------------------
`default_nettype none

module bus_chain_parent_tracker
   import bct_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input wire logic clock,
   input wire logic reset,
   bct_req_if.sink  req_ch,
   bct_rsp_if.source rsp_ch
);

   stack_cmd_type    cmd;
   stack_status_type stat;

   logic       accept;
   logic       no_port;
   addr_type   parent;
   addr_type   last_ff, last_in;
   logic       rsp_valid_ff;
   addr_type   node_ff, parent_ff;
   status_type status_ff, status_in;

   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign no_port      = (req_ch.open_ports == '0);
   assign parent       = req_ch.start_req ? req_ch.node_address : last_ff;

   always_comb begin
      cmd.valid = accept && !no_port;
      cmd.clear = req_ch.start_req;
      cmd.pop   = (req_ch.open_ports == PORTS_W'(1));
      cmd.data  = req_ch.node_address;
      if (req_ch.open_ports == PORTS_W'(3)) begin
         cmd.push_n = 2'd1;
      end else if (req_ch.open_ports >= PORTS_W'(4)) begin
         cmd.push_n = 2'd2;
      end else begin
         cmd.push_n = 2'd0;
      end
   end

   bct_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   always_comb begin
      if (!cmd.valid) begin
         last_in = last_ff;
      end else if (cmd.pop && !stat.empty) begin
         last_in = stat.top;
      end else begin
         last_in = req_ch.node_address;
      end
   end

   always_comb begin
      if (no_port) begin
         status_in = STATUS_NO_PORT;
      end else if (stat.overflow) begin
         status_in = STATUS_OVERFLOW;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff <= last_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         node_ff   <= req_ch.node_address;
         parent_ff <= parent;
         status_ff <= status_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.node_out       = node_ff;
   assign rsp_ch.parent_address = parent_ff;
   assign rsp_ch.status         = status_ff;

endmodule

`default_nettype wire
